// ----- design/binary_heap_priority_queue_assert.svh -----
// Assertion macros used by the heap queue checker.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define BHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bhpq_pkg.sv -----
// Shared constants, types and helpers of the binary heap priority queue.
package bhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 16;
  localparam int ENTRY_W  = KEY_W + PAY_W;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       accept;
    logic [1:0] code;
    logic       load_ins;
    logic       load_rem;
    logic       place;
    logic       rd_parent;
    logic       up_eval;
    logic       rd_tail;
    logic       load_tail;
    logic       rd_child;
    logic       dn_eval;
    logic       finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic single;
    logic at_root;
    logic up_move;
    logic dn_stop;
  } stat_t;

  // True when a has strictly higher priority than b
  function automatic logic outranks(input entry_t a, input entry_t b, input logic mode);
    outranks = mode ? (a.key > b.key) : (a.key < b.key);
  endfunction

endpackage

// ----- design/bhpq_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module bhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read two
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/bhpq_ctrl.sv -----
// Controller state machine sequencing heap insert and remove operations.
module bhpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           func,
  input  bhpq_pkg::stat_t stat,
  output bhpq_pkg::cmd_t  cmd,
  output logic           busy
);
  import bhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_EV,
    S_DN_TAIL,
    S_DN_LD,
    S_DN_RD,
    S_DN_EV,
    S_DONE
  } state_t;

  state_t state, state_next;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (func == FUNC_INSERT) begin
            if (stat.full) begin
              cmd.code   = ST_FULL;
              state_next = S_DONE;
            end else begin
              cmd.code     = ST_OK;
              cmd.load_ins = 1'b1;
              state_next   = S_UP_RD;
            end
          end else begin
            if (stat.empty) begin
              cmd.code   = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              cmd.code     = ST_OK;
              cmd.load_rem = 1'b1;
              state_next   = stat.single ? S_DONE : S_DN_TAIL;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.place  = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_EV;
        end
      end
      S_UP_EV: begin
        cmd.up_eval = 1'b1;
        state_next  = stat.up_move ? S_UP_RD : S_DONE;
      end
      S_DN_TAIL: begin
        cmd.rd_tail = 1'b1;
        state_next  = S_DN_LD;
      end
      S_DN_LD: begin
        cmd.load_tail = 1'b1;
        cmd.rd_child  = 1'b1;
        state_next    = S_DN_EV;
      end
      S_DN_RD: begin
        cmd.rd_child = 1'b1;
        state_next   = S_DN_EV;
      end
      S_DN_EV: begin
        cmd.dn_eval = 1'b1;
        state_next  = stat.dn_stop ? S_DONE : S_DN_RD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- design/bhpq_datapath.sv -----
// Datapath: heap memory, moving entry, root copy, count and result registers.
module bhpq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         order_mode,
  input  bhpq_pkg::cmd_t               cmd,
  output bhpq_pkg::stat_t              stat,
  input  logic [bhpq_pkg::KEY_W-1:0]   key,
  input  logic [bhpq_pkg::PAY_W-1:0]   payload,
  output logic                         done,
  output logic                         popped_valid,
  output logic [bhpq_pkg::KEY_W-1:0]   popped_key,
  output logic [bhpq_pkg::PAY_W-1:0]   popped_payload,
  output logic [1:0]                   op_status,
  output logic [bhpq_pkg::CNT_W-1:0]   entry_count,
  output logic                         is_empty,
  output logic [bhpq_pkg::KEY_W-1:0]   top_key,
  output logic [bhpq_pkg::PAY_W-1:0]   top_payload
);
  import bhpq_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  pos;
  entry_t             moving;
  entry_t             root;
  entry_t             popped;
  logic               pv;
  logic [1:0]         code;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  entry_t             wdata;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  logic [ENTRY_W-1:0] rdata_a_raw;
  logic [ENTRY_W-1:0] rdata_b_raw;
  entry_t             rdata_a;
  entry_t             rdata_b;

  logic [ADDR_W-1:0]  parent;
  logic [ADDR_W-1:0]  pos_dec;
  logic [CHILD_W-1:0] lc;
  logic [CHILD_W-1:0] rc;
  logic               l_win;
  logic               r_win;
  entry_t             best_ent;
  entry_t             chosen;
  logic [ADDR_W-1:0]  chosen_idx;

  assign rdata_a = entry_t'(rdata_a_raw);
  assign rdata_b = entry_t'(rdata_b_raw);

  // Neighbor addresses of the hole
  assign pos_dec = pos - ADDR_W'(1);
  assign parent  = pos_dec >> 1;
  assign lc      = {1'b0, pos, 1'b1};
  assign rc      = CHILD_W'({1'b0, pos, 1'b0}) + CHILD_W'(2);

  // Pick the child that outranks the moving entry, left first on a tie
  always_comb begin
    l_win    = (lc < CHILD_W'(count)) && outranks(rdata_a, moving, order_mode);
    best_ent = l_win ? rdata_a : moving;
    r_win    = (rc < CHILD_W'(count)) && outranks(rdata_b, best_ent, order_mode);
    if (r_win) begin
      chosen     = rdata_b;
      chosen_idx = rc[ADDR_W-1:0];
    end else begin
      chosen     = rdata_a;
      chosen_idx = lc[ADDR_W-1:0];
    end
  end

  // Status toward the controller
  always_comb begin
    stat.full    = (count == CNT_W'(CAPACITY));
    stat.empty   = (count == '0);
    stat.single  = (count == CNT_W'(1));
    stat.at_root = (pos == '0);
    stat.up_move = outranks(moving, rdata_a, order_mode);
    stat.dn_stop = !(l_win || r_win);
  end

  // Steer memory ports
  always_comb begin
    we      = cmd.place | cmd.up_eval | cmd.dn_eval;
    waddr   = pos;
    wdata   = moving;
    raddr_a = '0;
    raddr_b = rc[ADDR_W-1:0];
    if (cmd.up_eval && stat.up_move) begin
      wdata = rdata_a;
    end
    if (cmd.dn_eval && !stat.dn_stop) begin
      wdata = chosen;
    end
    if (cmd.rd_parent) begin
      raddr_a = parent;
    end
    if (cmd.rd_tail) begin
      raddr_a = count[ADDR_W-1:0];
    end
    if (cmd.rd_child) begin
      raddr_a = lc[ADDR_W-1:0];
    end
  end

  bhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a_raw),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b_raw)
  );

  // Advance count, hole and working entries
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.load_ins) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load_rem) begin
        count <= count - CNT_W'(1);
      end
    end
    if (cmd.accept) begin
      code <= cmd.code;
      pv   <= cmd.load_rem;
    end
    if (cmd.load_ins) begin
      moving <= '{key: key, payload: payload};
      pos    <= count[ADDR_W-1:0];
    end
    if (cmd.load_rem) begin
      popped <= root;
      pos    <= '0;
    end
    if (cmd.load_tail) begin
      moving <= rdata_a;
    end
    if (cmd.up_eval && stat.up_move) begin
      pos <= parent;
    end
    if (cmd.dn_eval && !stat.dn_stop) begin
      pos <= chosen_idx;
    end
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
  end

  // Register the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      popped_valid   <= pv;
      popped_key     <= pv ? popped.key : '0;
      popped_payload <= pv ? popped.payload : '0;
      op_status      <= code;
      entry_count    <= count;
      is_empty       <= (count == '0);
      top_key        <= (count != '0) ? root.key : '0;
      top_payload    <= (count != '0) ? root.payload : '0;
    end
  end

endmodule

// ----- design/binary_heap_priority_queue.sv -----
// Top level of the binary heap priority queue: config register and core.
//
// Usage: raise start with func, key and payload while busy is low; the
// operation is taken at that clock edge. func 0 inserts (key, payload),
// func 1 removes the top entry. Each operation returns one result
// transaction: done is high for exactly one cycle with popped_*, op_status,
// entry_count, is_empty and top_* valid. The receiver cannot stall done.
// A dropped insert, a remove on an empty heap and a remove of the last
// entry go straight to the result; any other insert climbs the new entry
// toward the root one level at a time, and any other remove loads the tail
// entry into the root's place and sinks it one level at a time. Each level
// is one registered read of the heap memory, then a compare and write.
// A new start may be taken in the cycle done is shown.
// order_mode sits at APB address 0 (bit 0: 0 smaller key first, 1 larger
// key first); write it only while idle. pready is always high.
// Reset empties the queue and clears order_mode; memory contents are left
// as they are and only data from occupied slots is ever used.
module binary_heap_priority_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic [bhpq_pkg::KEY_W-1:0] key,
  input  logic [bhpq_pkg::PAY_W-1:0] payload,
  output logic                       done,
  output logic                       popped_valid,
  output logic [bhpq_pkg::KEY_W-1:0] popped_key,
  output logic [bhpq_pkg::PAY_W-1:0] popped_payload,
  output logic [1:0]                 op_status,
  output logic [bhpq_pkg::CNT_W-1:0] entry_count,
  output logic                       is_empty,
  output logic [bhpq_pkg::KEY_W-1:0] top_key,
  output logic [bhpq_pkg::PAY_W-1:0] top_payload,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bhpq_pkg::*;

  localparam logic REG_ORDER_MODE = 1'b0;

  logic  order_mode;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  // Write the order mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ORDER_MODE)) begin
      order_mode <= pwdata[0];
    end
  end

  // Return register contents
  assign prdata = (paddr[2] == REG_ORDER_MODE) ? {31'd0, order_mode} : 32'd0;

  bhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bhpq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .order_mode     (order_mode),
    .cmd            (cmd),
    .stat           (stat),
    .key            (key),
    .payload        (payload),
    .done           (done),
    .popped_valid   (popped_valid),
    .popped_key     (popped_key),
    .popped_payload (popped_payload),
    .op_status      (op_status),
    .entry_count    (entry_count),
    .is_empty       (is_empty),
    .top_key        (top_key),
    .top_payload    (top_payload)
  );

endmodule

// ----- design/bhpq_checker.sv -----
// Port-level checker for the binary heap priority queue, bound to the top.
`include "binary_heap_priority_queue_assert.svh"

module bhpq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       popped_valid,
  input logic [1:0]                 op_status,
  input logic [bhpq_pkg::CNT_W-1:0] entry_count,
  input logic                       is_empty,
  input logic [bhpq_pkg::KEY_W-1:0] top_key
);
  import bhpq_pkg::*;

  // An accepted transaction keeps the block busy until its result
  `BHPQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !done, "busy missing after start")

  // A result is shown only once the block is idle again
  `BHPQ_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")

  // The empty flag agrees with the count
  `BHPQ_ASSERT_NOW(a_empty_count, done, is_empty == (entry_count == '0), "empty flag off")

  // An empty heap shows no top entry
  `BHPQ_ASSERT_NOW(a_empty_top, done && is_empty, top_key == '0, "top shown on empty heap")

  // A returned entry always comes with status ok
  `BHPQ_ASSERT_NOW(a_pop_ok, done && popped_valid, op_status == ST_OK, "pop with error status")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .popped_valid (popped_valid),
  .op_status    (op_status),
  .entry_count  (entry_count),
  .is_empty     (is_empty),
  .top_key      (top_key)
);
